[design/ipp_pkg.sv]
// ----------------------------------------------------------------------------
// IP address text parser package
// Shared types, character codes and parse state for the address parser.
// ----------------------------------------------------------------------------
package ipp_pkg;

  typedef enum logic [2:0] {
    PHASE_START = 3'd0,
    PHASE_LEAD  = 3'd1,
    PHASE_MAIN  = 3'd2,
    PHASE_V4    = 3'd3,
    PHASE_FAIL  = 3'd4
  } phase_e;

  localparam logic [1:0] ADDR_FAMILY = 2'd0;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;

  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [15:0] GROUP_LIMIT = 16'h0fff;
  localparam logic [3:0]  V4_BASE     = 4'd12;
  localparam logic [2:0]  OCTETS      = 3'd4;
  localparam logic [4:0]  ADDR_BYTES  = 5'd16;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } ipp_in_t;

  typedef struct packed {
    logic        parse_ok;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } ipp_out_t;

  typedef struct packed {
    phase_e          phase;
    logic [15:0][7:0] bytes;
    logic [4:0]      bw;
    logic            gap;
    logic [4:0]      gap_pos;
    logic [15:0]     hex;
    logic            saw_hex;
    logic [7:0]      tok;
    logic            tok_dec;
    logic [2:0]      oct_cnt;
    logic            saw_oct;
  } ipp_state_t;

  localparam ipp_state_t STATE_INIT = '{
    phase:   PHASE_START,
    bytes:   '0,
    bw:      5'd0,
    gap:     1'b0,
    gap_pos: 5'd0,
    hex:     16'd0,
    saw_hex: 1'b0,
    tok:     8'd0,
    tok_dec: 1'b1,
    oct_cnt: 3'd0,
    saw_oct: 1'b0
  };

endpackage

[design/ipp_step.sv]
// ----------------------------------------------------------------------------
// IP address parser character step
// Updates the parse state for one character under the selected family.
// ----------------------------------------------------------------------------
module ipp_step (
  input  logic               family_i,
  input  logic [7:0]         char_i,
  input  ipp_pkg::ipp_state_t state_i,
  output ipp_pkg::ipp_state_t state_o
);
  import ipp_pkg::*;

  logic        is_dec;
  logic        is_hex;
  logic        is_colon;
  logic        is_dot;
  logic [3:0]  digit;
  logic [3:0]  dot_base;
  logic        dot_start;
  logic [2:0]  dot_cnt;
  logic [7:0]  dot_acc;
  logic [11:0] dot_sum;
  logic [3:0]  dot_idx;
  logic [11:0] tok_sum;
  logic [3:0]  bw_idx;
  logic        run_dot;
  logic        run_v6;
  logic        ok;
  ipp_state_t  n;

  assign is_dec   = (char_i >= CHAR_0) && (char_i <= CHAR_9);
  assign is_hex   = is_dec || ((char_i >= CHAR_LA) && (char_i <= CHAR_LF)) ||
                    ((char_i >= CHAR_UA) && (char_i <= CHAR_UF));
  assign is_colon = (char_i == CHAR_COLON);
  assign is_dot   = (char_i == CHAR_DOT);
  assign digit    = is_dec ? char_i[3:0] : char_i[3:0] + 4'd9;

  assign dot_base  = family_i ? state_i.bw[3:0] : V4_BASE;
  assign dot_start = !state_i.saw_oct;
  assign dot_cnt   = dot_start ? state_i.oct_cnt + 3'd1 : state_i.oct_cnt;
  assign dot_idx   = dot_base + 4'(dot_cnt) - 4'd1;
  assign dot_acc   = dot_start ? 8'd0 : state_i.bytes[dot_idx];
  assign dot_sum   = 12'(dot_acc) * 12'd10 + 12'(digit);
  assign tok_sum   = 12'(state_i.tok) * 12'd10 + 12'(digit);
  assign bw_idx    = state_i.bw[3:0];

  always_comb begin
    n       = state_i;
    ok      = 1'b1;
    run_dot = 1'b0;
    run_v6  = 1'b0;
    if (state_i.phase != PHASE_FAIL) begin
      if (!family_i) begin
        n.phase = PHASE_MAIN;
        run_dot = 1'b1;
      end else if (state_i.phase == PHASE_START && is_colon) begin
        n.phase = PHASE_LEAD;
      end else if (state_i.phase == PHASE_LEAD) begin
        n.phase = PHASE_MAIN;
        if (is_colon) begin
          run_v6 = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end else if (state_i.phase == PHASE_V4) begin
        run_dot = 1'b1;
      end else begin
        n.phase = PHASE_MAIN;
        run_v6  = 1'b1;
      end

      if (run_dot) begin
        if (is_dec) begin
          if (dot_start && state_i.oct_cnt >= OCTETS) ok = 1'b0;
          if (dot_sum > OCTET_MAX) ok = 1'b0;
          n.oct_cnt        = dot_cnt;
          n.saw_oct        = 1'b1;
          n.bytes[dot_idx] = dot_sum[7:0];
        end else if (is_dot && state_i.saw_oct) begin
          if (state_i.oct_cnt == OCTETS) ok = 1'b0;
          n.saw_oct = 1'b0;
        end else begin
          ok = 1'b0;
        end
      end

      if (run_v6) begin
        if (is_hex) begin
          if (state_i.hex > GROUP_LIMIT) ok = 1'b0;
          n.hex     = {state_i.hex[11:0], digit};
          n.saw_hex = 1'b1;
          if (is_dec && state_i.tok_dec) begin
            if (tok_sum > OCTET_MAX) begin
              n.tok_dec = 1'b0;
            end else begin
              n.tok = tok_sum[7:0];
            end
          end else begin
            n.tok_dec = 1'b0;
          end
        end else if (is_colon) begin
          n.tok     = 8'd0;
          n.tok_dec = 1'b1;
          if (!state_i.saw_hex) begin
            if (state_i.gap) ok = 1'b0;
            n.gap     = 1'b1;
            n.gap_pos = state_i.bw;
          end else begin
            if (state_i.bw > 5'd14) ok = 1'b0;
            n.bytes[bw_idx]        = state_i.hex[15:8];
            n.bytes[bw_idx + 4'd1] = state_i.hex[7:0];
            n.bw                   = state_i.bw + 5'd2;
            n.hex                  = 16'd0;
            n.saw_hex              = 1'b0;
          end
        end else if (is_dot) begin
          if (state_i.bw > 5'd12 || !state_i.saw_hex || !state_i.tok_dec) ok = 1'b0;
          n.bytes[bw_idx] = state_i.tok;
          n.oct_cnt       = 3'd1;
          n.saw_oct       = 1'b0;
          n.phase         = PHASE_V4;
        end else begin
          ok = 1'b0;
        end
      end

      if (!ok) n.phase = PHASE_FAIL;
    end
  end

  assign state_o = n;

endmodule

[design/ipp_finish.sv]
// ----------------------------------------------------------------------------
// IP address parser finish
// Closes the last group, expands the gap and packs the result item.
// ----------------------------------------------------------------------------
module ipp_finish (
  input  logic                family_i,
  input  ipp_pkg::ipp_state_t state_i,
  output ipp_pkg::ipp_out_t   result_o
);
  import ipp_pkg::*;

  logic [15:0][7:0] fb;
  logic [15:0][7:0] sb;
  logic [4:0]       fbw;
  logic [4:0]       sh;
  logic [5:0]       gap_end;
  logic             bad;
  logic             ok4;
  logic             ok6;
  logic             ok;
  logic [63:0]      hi6;
  logic [63:0]      lo6;
  logic [63:0]      lo4;

  always_comb begin
    fb  = state_i.bytes;
    fbw = state_i.bw;
    bad = 1'b0;
    if (state_i.phase == PHASE_LEAD) begin
      bad = 1'b1;
    end else if (state_i.phase == PHASE_V4) begin
      if (state_i.oct_cnt < OCTETS) bad = 1'b1;
      fbw = state_i.bw + 5'd4;
    end else if (state_i.saw_hex) begin
      if (state_i.bw > 5'd14) bad = 1'b1;
      fb[state_i.bw[3:0]]        = state_i.hex[15:8];
      fb[state_i.bw[3:0] + 4'd1] = state_i.hex[7:0];
      fbw                        = state_i.bw + 5'd2;
    end
    if (state_i.gap && (fbw > ADDR_BYTES || state_i.gap_pos > fbw)) bad = 1'b1;
    ok6 = !bad && (state_i.gap || fbw == ADDR_BYTES);
  end

  assign sh      = ADDR_BYTES - fbw;
  assign gap_end = 6'(state_i.gap_pos) + 6'(sh);

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      if (state_i.gap && 5'(k) >= state_i.gap_pos) begin
        if (6'(k) < gap_end) begin
          sb[k] = 8'd0;
        end else begin
          sb[k] = fb[4'(k) - sh[3:0]];
        end
      end else begin
        sb[k] = fb[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      hi6[63 - 8 * k -: 8] = sb[k];
      lo6[63 - 8 * k -: 8] = sb[k + 8];
    end
  end

  assign lo4 = {32'd0, state_i.bytes[12], state_i.bytes[13],
                state_i.bytes[14], state_i.bytes[15]};
  assign ok4 = (state_i.oct_cnt == OCTETS);
  assign ok  = (state_i.phase != PHASE_FAIL) && (family_i ? ok6 : ok4);

  assign result_o.parse_ok     = ok;
  assign result_o.address_high = (ok && family_i) ? hi6 : 64'd0;
  assign result_o.address_low  = !ok ? 64'd0 : (family_i ? lo6 : lo4);

endmodule

[design/ip_address_text_parser.sv]
// ----------------------------------------------------------------------------
// IP address text parser
// Parses dotted IPv4 or textual IPv6 address strings, one character per item.
// ----------------------------------------------------------------------------
// The parser takes one character every clock cycle and returns one result per
// string, in the output register in the cycle after the last character is taken.
// Input stalls only while a finished result waits and out_ready_i is low.
// The cycle time is set by the per-character state update followed, on the
// last character, by the final group store and the fixed 16-byte gap mux.
// Register address_family at byte address 0 selects IPv4 (0) or IPv6 (1); the user
// must write it only between strings, as the block itself does not enforce this.
module ip_address_text_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ipp_pkg::ipp_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ipp_pkg::ipp_out_t   out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ipp_pkg::*;

  logic       family_q;
  ipp_state_t state_q;
  ipp_state_t state_d;
  ipp_state_t step_state;
  ipp_out_t   result;
  ipp_out_t   out_data_q;
  logic       out_valid_q;
  logic       in_fire;

  assign pready     = 1'b1;
  assign prdata     = (paddr == ADDR_FAMILY) ? {31'd0, family_q} : 32'd0;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  ipp_step u_step (
    .family_i (family_q),
    .char_i   (in_data_i.text_char),
    .state_i  (state_q),
    .state_o  (step_state)
  );

  ipp_finish u_finish (
    .family_i (family_q),
    .state_i  (step_state),
    .result_o (result)
  );

  always_comb begin
    state_d = state_q;
    if (in_fire) begin
      state_d = in_data_i.last_char ? STATE_INIT : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q    <= 1'b0;
      state_q     <= STATE_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_FAMILY) begin
        family_q <= pwdata[0];
      end
      state_q <= state_d;
      if (in_fire && in_data_i.last_char) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last_char) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
